// ----- design/ird_pkg.sv -----
// package for the pulse-distance infrared decoder
// holds request/result/config types, phase and command codes, reset values
// no dependencies
package ird_pkg;

    localparam int INTERVAL_W = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAME_W    = 32;
    localparam int BUTTON_W   = 8;
    localparam int BUTTON_LSB = 8;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEAD_MARK  = 3'd1,
        PH_LEAD_SPACE = 3'd2,
        PH_BIT_MARK   = 3'd3,
        PH_BIT_SPACE  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        CMD_EDGE     = 2'd0,
        CMD_OVERFLOW = 2'd1,
        CMD_REARM    = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEAD_MARK_MIN  = 3'd0,
        CFG_LEAD_MARK_MAX  = 3'd1,
        CFG_LEAD_SPACE_MIN = 3'd2,
        CFG_LEAD_SPACE_MAX = 3'd3,
        CFG_SHORT_MIN      = 3'd4,
        CFG_BIT_MARK_MAX   = 3'd5,
        CFG_BIT_SPACE_MAX  = 3'd6,
        CFG_ONE_THRESHOLD  = 3'd7
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_LEAD_MARK_MIN  = 16'd8500;
    localparam logic [CFG_W-1:0] RST_LEAD_MARK_MAX  = 16'd9500;
    localparam logic [CFG_W-1:0] RST_LEAD_SPACE_MIN = 16'd4000;
    localparam logic [CFG_W-1:0] RST_LEAD_SPACE_MAX = 16'd5000;
    localparam logic [CFG_W-1:0] RST_SHORT_MIN      = 16'd400;
    localparam logic [CFG_W-1:0] RST_BIT_MARK_MAX   = 16'd700;
    localparam logic [CFG_W-1:0] RST_BIT_SPACE_MAX  = 16'd1800;
    localparam logic [CFG_W-1:0] RST_ONE_THRESHOLD  = 16'd1000;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [INTERVAL_W-1:0] interval_us;
    } t_request;

    typedef struct packed {
        logic [2:0]          phase;
        logic                frame_done;
        logic                timing_error;
        logic [BUTTON_W-1:0] button;
        logic [FRAME_W-1:0]  frame_code;
        logic                armed;
    } t_result;

    typedef struct packed {
        logic [CFG_W-1:0] lead_mark_min;
        logic [CFG_W-1:0] lead_mark_max;
        logic [CFG_W-1:0] lead_space_min;
        logic [CFG_W-1:0] lead_space_max;
        logic [CFG_W-1:0] short_min;
        logic [CFG_W-1:0] bit_mark_max;
        logic [CFG_W-1:0] bit_space_max;
        logic [CFG_W-1:0] one_threshold;
    } t_cfg;

endpackage

// ----- design/ir_pulse_distance_decoder.sv -----
// top level of the pulse-distance (nec style) infrared frame decoder
// depends on ird_pkg, ird_cfg_regs and ird_core
//
//  channel   direction  handshake                 payload
//  request   in         i_req_valid / o_req_ready  i_req  (t_request: cmd, interval_us)
//  result    out        o_res_valid / i_res_ready  o_res  (t_result)
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_wdata
//
// one request per clock sustained while the result side keeps taking results; the result is
// registered (input register, then decode logic into the result register)
// synchronous active-low reset: idle, armed, code cleared, windows to defaults
// a stalled result holds the result register; the input register still takes a
// request while it is empty, then ready drops until the result side moves
module ir_pulse_distance_decoder import ird_pkg::*; #(
    parameter int CODE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    input  t_request             i_req,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output t_result              o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    // input register stage
    logic     r_in_valid;
    t_request r_in;
    // result register stage
    logic     r_out_valid;
    t_result  r_out;

    t_cfg    w_cfg;
    t_result w_res;
    logic    w_fire;
    logic    w_accept;

    // the request in the input register is decoded when the result slot frees up
    assign w_fire      = r_in_valid && (!r_out_valid || i_res_ready);
    assign o_req_ready = !r_in_valid || w_fire;
    assign w_accept    = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    ird_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // frame state advances only when a decoded result is written
    ird_core #(
        .CODE_BITS (CODE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_req   (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_res_ready |=> r_out_valid && $stable(r_out))
        else $error("stalled result was overwritten or dropped");
    a_fire_needs_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> r_in_valid)
        else $error("decode fired with an empty input register");
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_out_valid && !i_res_ready |-> !o_req_ready)
        else $error("request taken while both stages were full");
`endif

endmodule

// ----- design/ird_cfg_regs.sv -----
// timing window registers of the infrared decoder
// depends on ird_pkg for the register index codes and reset values
module ird_cfg_regs import ird_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lead_mark_min  <= RST_LEAD_MARK_MIN;
            r_cfg.lead_mark_max  <= RST_LEAD_MARK_MAX;
            r_cfg.lead_space_min <= RST_LEAD_SPACE_MIN;
            r_cfg.lead_space_max <= RST_LEAD_SPACE_MAX;
            r_cfg.short_min      <= RST_SHORT_MIN;
            r_cfg.bit_mark_max   <= RST_BIT_MARK_MAX;
            r_cfg.bit_space_max  <= RST_BIT_SPACE_MAX;
            r_cfg.one_threshold  <= RST_ONE_THRESHOLD;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LEAD_MARK_MIN:  r_cfg.lead_mark_min  <= i_cfg_wdata;
                CFG_LEAD_MARK_MAX:  r_cfg.lead_mark_max  <= i_cfg_wdata;
                CFG_LEAD_SPACE_MIN: r_cfg.lead_space_min <= i_cfg_wdata;
                CFG_LEAD_SPACE_MAX: r_cfg.lead_space_max <= i_cfg_wdata;
                CFG_SHORT_MIN:      r_cfg.short_min      <= i_cfg_wdata;
                CFG_BIT_MARK_MAX:   r_cfg.bit_mark_max   <= i_cfg_wdata;
                CFG_BIT_SPACE_MAX:  r_cfg.bit_space_max  <= i_cfg_wdata;
                CFG_ONE_THRESHOLD:  r_cfg.one_threshold  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- design/ird_core.sv -----
// frame state machine of the infrared decoder: window checks, bit shifter, latch
// depends on ird_pkg for phase/command codes and the request, result, config types
module ird_core import ird_pkg::*; #(
    parameter int CODE_BITS = 32
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_request i_req,
    input  t_cfg     i_cfg,
    output t_result  o_res
);

    localparam int CNT_W  = $clog2(CODE_BITS);
    localparam int LOW_W  = (CODE_BITS < FRAME_W) ? CODE_BITS : FRAME_W;
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(CODE_BITS - 1);

    t_phase               r_phase, n_phase;
    logic [CODE_BITS-1:0] r_shift, n_shift;
    logic [CNT_W-1:0]     r_bits, n_bits;
    logic                 r_armed, n_armed;
    logic [FRAME_W-1:0]   r_last, n_last;
    logic                 w_done, w_err;

    logic [INTERVAL_W-1:0] w_t;
    logic                  w_lead_mark_ok, w_lead_space_ok, w_mark_ok, w_space_ok, w_one;
    logic [CODE_BITS-1:0]  w_shifted;

    assign w_t             = i_req.interval_us;
    assign w_lead_mark_ok  = (w_t >= i_cfg.lead_mark_min) && (w_t <= i_cfg.lead_mark_max);
    assign w_lead_space_ok = (w_t >= i_cfg.lead_space_min) && (w_t <= i_cfg.lead_space_max);
    assign w_mark_ok       = (w_t >= i_cfg.short_min) && (w_t <= i_cfg.bit_mark_max);
    assign w_space_ok      = (w_t >= i_cfg.short_min) && (w_t <= i_cfg.bit_space_max);
    assign w_one           = w_t > i_cfg.one_threshold;
    assign w_shifted       = {r_shift[CODE_BITS-2:0], w_one};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_shift <= '0;
            r_bits  <= '0;
            r_armed <= 1'b1;
            r_last  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_shift <= n_shift;
            r_bits  <= n_bits;
            r_armed <= n_armed;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_armed = r_armed;
        n_last  = r_last;
        w_done  = 1'b0;
        w_err   = 1'b0;
        case (t_cmd'(i_req.cmd))
            CMD_OVERFLOW: n_phase = PH_IDLE;
            CMD_REARM:    n_armed = 1'b1;
            CMD_EDGE: begin
                if (r_armed) begin
                    case (r_phase)
                        PH_IDLE: begin
                            // starting edge: no timing check
                            n_shift = '0;
                            n_bits  = '0;
                            n_phase = PH_LEAD_MARK;
                        end
                        PH_LEAD_MARK: begin
                            if (w_lead_mark_ok) begin
                                n_phase = PH_LEAD_SPACE;
                            end else begin
                                n_phase = PH_IDLE;
                                w_err   = 1'b1;
                            end
                        end
                        PH_LEAD_SPACE: begin
                            if (w_lead_space_ok) begin
                                n_phase = PH_BIT_MARK;
                            end else begin
                                n_phase = PH_IDLE;
                                w_err   = 1'b1;
                            end
                        end
                        PH_BIT_MARK: begin
                            if (w_mark_ok) begin
                                n_phase = PH_BIT_SPACE;
                            end else begin
                                n_phase = PH_IDLE;
                                w_err   = 1'b1;
                            end
                        end
                        PH_BIT_SPACE: begin
                            if (w_space_ok) begin
                                n_shift = w_shifted;
                                if (r_bits == LAST_BIT) begin
                                    n_last  = FRAME_W'(w_shifted[LOW_W-1:0]);
                                    n_bits  = '0;
                                    n_phase = PH_IDLE;
                                    n_armed = 1'b0;
                                    w_done  = 1'b1;
                                end else begin
                                    n_bits  = r_bits + 1'b1;
                                    n_phase = PH_BIT_MARK;
                                end
                            end else begin
                                n_phase = PH_IDLE;
                                w_err   = 1'b1;
                            end
                        end
                        default: n_phase = PH_IDLE;
                    endcase
                end
            end
            default: ;
        endcase
    end

    assign o_res.phase        = n_phase;
    assign o_res.frame_done   = w_done;
    assign o_res.timing_error = w_err;
    assign o_res.button       = n_last[BUTTON_LSB +: BUTTON_W];
    assign o_res.frame_code   = n_last;
    assign o_res.armed        = n_armed;

`ifndef NO_ASSERTIONS
    a_done_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_done |=> !r_armed && (r_phase == PH_IDLE))
        else $error("frame completion did not disarm and idle the decoder");
    a_err_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_err |=> (r_phase == PH_IDLE) && $stable(r_last))
        else $error("timing error left decoder out of idle or changed the code");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_done && w_err))
        else $error("frame done and timing error together");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_phase) && $stable(r_armed) && $stable(r_bits))
        else $error("decoder state moved without a request");
`endif

endmodule

// ----- sim/ird_decode_monitor.sv -----
`timescale 1ns / 1ps
// watches the request, result and config ports of the infrared frame decoder,
// decodes every accepted request on its own and compares the results field by field
// depends on ird_pkg
module ird_decode_monitor import ird_pkg::*; #(
    parameter int CODE_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  t_request             i_req,
    input  logic                 i_res_valid,
    input  logic                 i_res_ready,
    input  t_result              i_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output int                   o_fail_count,
    output int                   o_pending
);

    t_cfg                   windows;
    t_phase                 phase_q;
    logic [CODE_BITS-1:0]   shift_q;
    logic [5:0]             bits_q;
    logic                   armed_q;
    logic [FRAME_W-1:0]     code_q;

    t_result decodes_due[$];
    t_result want;
    int      fails = 0;

    function automatic bit in_range(input logic [INTERVAL_W-1:0] v,
                                    input logic [CFG_W-1:0] lo, hi);
        return v >= lo && v <= hi;
    endfunction

    // advances the decoder state by one request and returns what it should report
    function automatic t_result decode_event(input t_request rq);
        t_result                r;
        logic [INTERVAL_W-1:0]  t;
        logic                   done;
        logic                   err;
        t    = rq.interval_us;
        done = 1'b0;
        err  = 1'b0;
        case (rq.cmd)
            CMD_OVERFLOW: phase_q = PH_IDLE;
            CMD_REARM:    armed_q = 1'b1;
            CMD_EDGE: begin
                if (armed_q) begin
                    case (phase_q)
                        PH_IDLE: begin
                            shift_q = '0;
                            bits_q  = '0;
                            phase_q = PH_LEAD_MARK;
                        end
                        PH_LEAD_MARK: begin
                            if (in_range(t, windows.lead_mark_min, windows.lead_mark_max))
                                phase_q = PH_LEAD_SPACE;
                            else begin
                                phase_q = PH_IDLE;
                                err     = 1'b1;
                            end
                        end
                        PH_LEAD_SPACE: begin
                            if (in_range(t, windows.lead_space_min, windows.lead_space_max))
                                phase_q = PH_BIT_MARK;
                            else begin
                                phase_q = PH_IDLE;
                                err     = 1'b1;
                            end
                        end
                        PH_BIT_MARK: begin
                            if (in_range(t, windows.short_min, windows.bit_mark_max))
                                phase_q = PH_BIT_SPACE;
                            else begin
                                phase_q = PH_IDLE;
                                err     = 1'b1;
                            end
                        end
                        PH_BIT_SPACE: begin
                            if (in_range(t, windows.short_min, windows.bit_space_max)) begin
                                shift_q = {shift_q[CODE_BITS-2:0], t > windows.one_threshold};
                                if (int'(bits_q) + 1 >= CODE_BITS) begin
                                    code_q  = shift_q[FRAME_W-1:0];
                                    bits_q  = '0;
                                    phase_q = PH_IDLE;
                                    armed_q = 1'b0;
                                    done    = 1'b1;
                                end else begin
                                    bits_q  = bits_q + 6'd1;
                                    phase_q = PH_BIT_MARK;
                                end
                            end else begin
                                phase_q = PH_IDLE;
                                err     = 1'b1;
                            end
                        end
                        default: phase_q = PH_IDLE;
                    endcase
                end
            end
            default: ;
        endcase
        r.phase        = phase_q;
        r.frame_done   = done;
        r.timing_error = err;
        r.button       = code_q[BUTTON_LSB +: BUTTON_W];
        r.frame_code   = code_q;
        r.armed        = armed_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [FRAME_W-1:0] want_v, got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0h, actual %0h", name, want_v, got_v);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            windows = '{RST_LEAD_MARK_MIN, RST_LEAD_MARK_MAX, RST_LEAD_SPACE_MIN,
                        RST_LEAD_SPACE_MAX, RST_SHORT_MIN, RST_BIT_MARK_MAX,
                        RST_BIT_SPACE_MAX, RST_ONE_THRESHOLD};
            phase_q = PH_IDLE;
            shift_q = '0;
            bits_q  = '0;
            armed_q = 1'b1;
            code_q  = '0;
            decodes_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEAD_MARK_MIN:  windows.lead_mark_min  = i_cfg_wdata;
                    CFG_LEAD_MARK_MAX:  windows.lead_mark_max  = i_cfg_wdata;
                    CFG_LEAD_SPACE_MIN: windows.lead_space_min = i_cfg_wdata;
                    CFG_LEAD_SPACE_MAX: windows.lead_space_max = i_cfg_wdata;
                    CFG_SHORT_MIN:      windows.short_min      = i_cfg_wdata;
                    CFG_BIT_MARK_MAX:   windows.bit_mark_max   = i_cfg_wdata;
                    CFG_BIT_SPACE_MAX:  windows.bit_space_max  = i_cfg_wdata;
                    CFG_ONE_THRESHOLD:  windows.one_threshold  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                decodes_due.push_back(decode_event(i_req));
            if (i_res_valid && i_res_ready) begin
                if (decodes_due.size() == 0) begin
                    $error("result with no request outstanding");
                    fails++;
                end else begin
                    want = decodes_due.pop_front();
                    check_field("phase",        want.phase,        i_res.phase);
                    check_field("frame_done",   want.frame_done,   i_res.frame_done);
                    check_field("timing_error", want.timing_error, i_res.timing_error);
                    check_field("button",       want.button,       i_res.button);
                    check_field("frame_code",   want.frame_code,   i_res.frame_code);
                    check_field("armed",        want.armed,        i_res.armed);
                end
            end
        end
        o_pending    <= decodes_due.size();
        o_fail_count <= fails;
    end

endmodule

// ----- sim/tb_ir_pulse_distance_decoder.sv -----
`timescale 1ns / 1ps
// stimulus and verdict for the pulse-distance infrared frame decoder
// depends on ird_pkg, ir_pulse_distance_decoder and ird_decode_monitor
module tb_ir_pulse_distance_decoder;
    import ird_pkg::*;

    // cmd value outside the defined set, the block must ignore it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    t_request             req       = '0;
    logic                 res_valid;
    logic                 res_ready = 1'b0;
    t_result              res;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    int                   fail_count;
    int                   pending;

    // knobs shared by the request driver and the result side
    bit gaps_on   = 1'b1;
    bit stall_on  = 1'b1;
    int hold_left = 0;
    int sent      = 0;

    // current timing windows, mirrored here only to shape well-formed frames
    t_cfg windows = '{RST_LEAD_MARK_MIN, RST_LEAD_MARK_MAX, RST_LEAD_SPACE_MIN,
                      RST_LEAD_SPACE_MAX, RST_SHORT_MIN, RST_BIT_MARK_MAX,
                      RST_BIT_SPACE_MAX, RST_ONE_THRESHOLD};

    always #10 clk = ~clk;

    ir_pulse_distance_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    ird_decode_monitor u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res        (res),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: a long hold-off when asked, otherwise ready drops at random
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                res_ready <= 1'b0;
                hold_left--;
            end else begin
                res_ready <= !(stall_on && $urandom_range(99) < 17);
            end
        end
    end

    // one request, at random with req_valid held low in front; returns at the accepting edge
    task automatic send(input logic [1:0] cmd, input logic [INTERVAL_W-1:0] t);
        if (gaps_on && $urandom_range(99) < 20) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{cmd: cmd, interval_us: t};
        do @(posedge clk); while (!req_ready);
        sent++;
    endtask

    // stop offering requests until every result has come back and the pipe is quiet
    task automatic drain();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic program_windows(input t_cfg c);
        write_reg(CFG_LEAD_MARK_MIN,  c.lead_mark_min);
        write_reg(CFG_LEAD_MARK_MAX,  c.lead_mark_max);
        write_reg(CFG_LEAD_SPACE_MIN, c.lead_space_min);
        write_reg(CFG_LEAD_SPACE_MAX, c.lead_space_max);
        write_reg(CFG_SHORT_MIN,      c.short_min);
        write_reg(CFG_BIT_MARK_MAX,   c.bit_mark_max);
        write_reg(CFG_BIT_SPACE_MAX,  c.bit_space_max);
        write_reg(CFG_ONE_THRESHOLD,  c.one_threshold);
        cfg_we  <= 1'b0;
        windows = c;
    endtask

    // interval inside [lo, hi], leaning on the boundaries; anything when the window is empty
    function automatic logic [INTERVAL_W-1:0] pick_in(input logic [CFG_W-1:0] lo, hi);
        int unsigned r;
        if (lo > hi)
            return INTERVAL_W'($urandom_range(16'hFFFF, 0));
        r = $urandom_range(99);
        if (r < 8)
            return lo;
        if (r < 16)
            return hi;
        return INTERVAL_W'($urandom_range(hi, lo));
    endfunction

    // interval just outside or far outside the window, when one exists
    function automatic logic [INTERVAL_W-1:0] pick_out(input logic [CFG_W-1:0] lo, hi);
        bit below;
        below = (lo != 0) && (hi == 16'hFFFF || $urandom_range(1) == 1);
        if (below)
            return $urandom_range(1) ? lo - 16'd1 : INTERVAL_W'($urandom_range(lo - 1, 0));
        if (hi != 16'hFFFF)
            return $urandom_range(1) ? hi + 16'd1
                                     : INTERVAL_W'($urandom_range(16'hFFFF, hi + 1));
        return pick_in(lo, hi);
    endfunction

    // starting edge, leader mark and space, then 32 mark/space pairs with random bits;
    // a few frames carry a bad interval or an overflow/rearm/unused command in the middle
    task automatic send_frame();
        int                    abort_at;
        bit                    completed;
        logic [CFG_W-1:0]      lo;
        logic [CFG_W-1:0]      hi;
        logic [INTERVAL_W-1:0] t;
        abort_at  = ($urandom_range(99) < 10) ? int'($urandom_range(66, 1)) : -1;
        completed = 1'b0;
        lo        = '0;
        hi        = '0;
        for (int k = 0; k < 67; k++) begin
            if (k == abort_at) begin
                case ($urandom_range(2))
                    0: begin
                        send(CMD_OVERFLOW, INTERVAL_W'($urandom));
                        break;
                    end
                    1: send(CMD_REARM, INTERVAL_W'($urandom));
                    default: send(CMD_UNUSED, INTERVAL_W'($urandom));
                endcase
            end
            if (k == 0) begin
                t = INTERVAL_W'($urandom);
            end else begin
                if (k == 1) begin
                    lo = windows.lead_mark_min;
                    hi = windows.lead_mark_max;
                end else if (k == 2) begin
                    lo = windows.lead_space_min;
                    hi = windows.lead_space_max;
                end else if (k % 2 == 1) begin
                    lo = windows.short_min;
                    hi = windows.bit_mark_max;
                end else begin
                    lo = windows.short_min;
                    hi = windows.bit_space_max;
                end
                t = ($urandom_range(999) < 4) ? pick_out(lo, hi) : pick_in(lo, hi);
            end
            send(CMD_EDGE, t);
            // a bad interval drops the decoder back to idle, the frame is over
            if (k > 0 && !(t >= lo && t <= hi))
                break;
            if (k == 66)
                completed = 1'b1;
        end
        // edges while disarmed must be ignored
        if (completed && $urandom_range(99) < 30)
            repeat ($urandom_range(3, 1)) send(CMD_EDGE, INTERVAL_W'($urandom));
        send(CMD_REARM, INTERVAL_W'($urandom));
    endtask

    // arbitrary requests, any command, then an overflow to get back to idle
    task automatic noise_burst();
        repeat ($urandom_range(6, 1)) send(2'($urandom_range(3, 0)), INTERVAL_W'($urandom));
        send(CMD_OVERFLOW, INTERVAL_W'($urandom));
    endtask

    task automatic run_traffic(input int n);
        int stop;
        stop = sent + n;
        while (sent < stop) begin
            if ($urandom_range(99) < 88)
                send_frame();
            else
                noise_burst();
        end
    endtask

    initial begin
        t_cfg c;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset windows: boundaries, every command, the special cases
        send(CMD_EDGE, 16'd0);                        // starting edge, no timing check
        send(CMD_EDGE, RST_LEAD_MARK_MIN);
        send(CMD_EDGE, RST_LEAD_SPACE_MAX);
        send(CMD_EDGE, RST_SHORT_MIN);
        send(CMD_EDGE, RST_ONE_THRESHOLD + 16'd1);    // one bit
        send(CMD_EDGE, RST_BIT_MARK_MAX);
        send(CMD_EDGE, RST_ONE_THRESHOLD);            // exactly at threshold, zero bit
        send(CMD_UNUSED, 16'hFFFF);                   // must change nothing
        send(CMD_REARM, 16'd0);                       // phase stays
        send(CMD_EDGE, RST_SHORT_MIN - 16'd1);        // bit mark too short
        send(CMD_EDGE, 16'hFFFF);
        send(CMD_EDGE, RST_LEAD_MARK_MAX + 16'd1);    // leader mark too long
        send(CMD_EDGE, 16'h5555);
        send(CMD_OVERFLOW, 16'hAAAA);                 // overflow mid-frame, no error flag
        send(CMD_OVERFLOW, 16'd0);                    // overflow while idle
        send(CMD_EDGE, 16'd0);
        send(CMD_EDGE, RST_LEAD_MARK_MAX);
        send(CMD_EDGE, RST_LEAD_SPACE_MIN - 16'd1);   // leader space too short
        send(CMD_EDGE, 16'd0);
        send(CMD_EDGE, RST_LEAD_MARK_MIN - 16'd1);    // leader mark too short
        send(CMD_EDGE, 16'd0);
        send(CMD_EDGE, RST_LEAD_MARK_MIN);
        send(CMD_EDGE, RST_LEAD_SPACE_MIN);
        send(CMD_EDGE, RST_SHORT_MIN);
        send(CMD_EDGE, RST_BIT_SPACE_MAX + 16'd1);    // bit space too long

        // random frames under reset windows, with a full pause in the middle
        run_traffic(150);
        drain();
        run_traffic(150);

        // windows jittered around the defaults, no idling on either side
        drain();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        c = '{16'($urandom_range(8800, 8000)), 16'($urandom_range(10000, 9200)),
              16'($urandom_range(4400, 3600)), 16'($urandom_range(5400, 4600)),
              16'($urandom_range(500, 300)),   16'($urandom_range(800, 600)),
              16'($urandom_range(2000, 1600)), 16'($urandom_range(1200, 800))};
        program_windows(c);
        run_traffic(300);

        // fully open windows, threshold zero: nearly every bit a one;
        // the result side holds off long enough for the block to stall its input
        drain();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        program_windows('{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0});
        hold_left = 300;
        run_traffic(250);

        // fully open windows, threshold at top: every bit a zero
        drain();
        program_windows('{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF,
                          16'hFFFF});
        run_traffic(250);

        // single-value windows, a one only at the very top of the bit space
        drain();
        program_windows('{16'd9000, 16'd9000, 16'd4500, 16'd4500, 16'd560, 16'd560,
                          16'd1690, 16'd1689});
        run_traffic(250);

        // everything zero: only a zero interval passes
        drain();
        program_windows('0);
        run_traffic(150);

        // inverted windows: no interval passes
        drain();
        program_windows('{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0});
        run_traffic(80);

        // back to the defaults, written explicitly
        drain();
        program_windows('{RST_LEAD_MARK_MIN, RST_LEAD_MARK_MAX, RST_LEAD_SPACE_MIN,
                          RST_LEAD_SPACE_MAX, RST_SHORT_MIN, RST_BIT_MARK_MAX,
                          RST_BIT_SPACE_MAX, RST_ONE_THRESHOLD});
        run_traffic(300);

        drain();
        if (fail_count == 0 && pending == 0)
            $display("[ir_pulse_distance_decoder] OK");
        else
            $display("[ir_pulse_distance_decoder] ERROR");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("[ir_pulse_distance_decoder] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
design/ird_pkg.sv
design/ird_cfg_regs.sv
design/ird_core.sv
design/ir_pulse_distance_decoder.sv
sim/ird_decode_monitor.sv
sim/tb_ir_pulse_distance_decoder.sv
